@@ rtl/core/dltq_pkg.sv @@
// ----------------------------------------------------------------------------
// Delta-list timer queue package
// Request and result types, list entry layout and operation and status codes.
// ----------------------------------------------------------------------------
package dltq_pkg;

  localparam int KIND_W   = 2;
  localparam int HANDLE_W = 8;
  localparam int DELTA_W  = 16;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;
  localparam int TICK_W   = 10;

  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd3;

  localparam logic [TICK_W-1:0] TICK_RESET = 10'd10;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] task_handle;
    logic [DELTA_W-1:0]  first_delay;
    logic [DELTA_W-1:0]  repeat_period;
    logic [SLOT_W-1:0]   slot;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   placed_slot;
    logic                fired_valid;
    logic [HANDLE_W-1:0] fired_handle;
  } res_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [DELTA_W-1:0]  delta;
    logic [DELTA_W-1:0]  period;
  } entry_t;

endpackage

@@ rtl/core/dltq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dltq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/dltq_div.sv @@
// ----------------------------------------------------------------------------
// Tick divider
// Restoring divider, one quotient bit per cycle; a zero divisor passes the
// dividend through.
// ----------------------------------------------------------------------------
module dltq_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [dltq_pkg::DELTA_W-1:0] dividend,
  input  logic [dltq_pkg::TICK_W-1:0]  divisor,
  output logic                         done,
  output logic [dltq_pkg::DELTA_W-1:0] quotient
);

  localparam int DW = dltq_pkg::DELTA_W;
  localparam int TW = dltq_pkg::TICK_W;

  logic                  busy;
  logic [$clog2(DW)-1:0] cnt;
  logic [TW-1:0]         rem;
  logic [TW-1:0]         dvs;
  logic [TW:0]           trial;
  logic                  fits;

  assign trial = {rem, quotient[DW-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= (divisor != '0);
        done <= (divisor == '0);
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
      cnt      <= '1;
    end else if (busy) begin
      rem      <= fits ? TW'(trial - {1'b0, dvs}) : trial[TW-1:0];
      quotient <= {quotient[DW-2:0], fits};
      cnt      <= cnt - 1'b1;
    end
  end

endmodule

@@ rtl/core/delta_list_task_timer_queue.sv @@
// ----------------------------------------------------------------------------
// Delta-list timer queue
// Sorted list of timed tasks held in one RAM, worked by a read-modify-write
// sequencer with a shared tick divider.
// ----------------------------------------------------------------------------
// One request is worked at a time; a new one is taken while the previous
// result still waits on the output. All entries sit in a single RAM with
// registered read data, and the sequencer walks the list on that port. A
// tick lowers the head's delta unless it is zero; an idle dispatch finds the
// head's delta not yet zero. A delete moves each entry behind the slot down,
// folding the removed delta into the next. An add runs the divider, walks the
// list, shifts the entries behind the slot up and places the new entry. A
// periodic dispatch is a delete of the head followed by an add. The RAM is
// never cleared: only entries below the count are read for results.
// ----------------------------------------------------------------------------
module delta_list_task_timer_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  dltq_pkg::cmd_t              cmd,
  output logic                        res_valid,
  input  logic                        res_ready,
  output dltq_pkg::res_t              res,
  input  logic                        cfg_we,
  input  logic [dltq_pkg::TICK_W-1:0] cfg_wdata
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = (CW > dltq_pkg::SLOT_W) ? CW : dltq_pkg::SLOT_W;
  localparam int EW = $bits(dltq_pkg::entry_t);
  localparam int DW = dltq_pkg::DELTA_W;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DIV       = 4'd1;
  localparam logic [3:0] S_WALK      = 4'd2;
  localparam logic [3:0] S_SHIFT     = 4'd3;
  localparam logic [3:0] S_PLACE     = 4'd4;
  localparam logic [3:0] S_REM_HEAD  = 4'd5;
  localparam logic [3:0] S_REM_SHIFT = 4'd6;
  localparam logic [3:0] S_DISP      = 4'd7;
  localparam logic [3:0] S_TICK      = 4'd8;
  localparam logic [3:0] S_FINISH    = 4'd9;

  logic [3:0]                   state, state_next;
  logic [CW-1:0]                count, count_next;
  logic [IW-1:0]                idx, idx_next;
  logic [IW-1:0]                pos, pos_next;
  logic [DW-1:0]                rem, rem_next;
  logic [DW-1:0]                hold_delta, hold_delta_next;
  logic [dltq_pkg::HANDLE_W-1:0] ins_handle, ins_handle_next;
  logic [DW-1:0]                ins_period, ins_period_next;
  logic                         readd, readd_next;
  logic [dltq_pkg::TICK_W-1:0]  tick_length;
  dltq_pkg::res_t               result, result_next;
  logic                         res_valid_next;
  dltq_pkg::res_t               res_next;

  logic                         ram_we;
  logic [IW-1:0]                ram_waddr;
  dltq_pkg::entry_t             ram_wdata;
  logic [IW-1:0]                ram_raddr;
  logic [EW-1:0]                ram_rdata;
  dltq_pkg::entry_t             rd;

  logic                         div_start;
  logic [DW-1:0]                div_dividend;
  logic                         div_done;
  logic [DW-1:0]                div_quotient;

  logic [IW-1:0]                count_last;
  logic [DW:0]                  fold_sum;
  logic [DW-1:0]                fold_delta;

  assign rd         = dltq_pkg::entry_t'(ram_rdata);
  assign count_last = IW'(count - 1'b1);
  assign fold_sum   = {1'b0, rd.delta} + {1'b0, hold_delta};
  assign fold_delta = fold_sum[DW] ? '1 : fold_sum[DW-1:0];
  assign cmd_ready  = (state == S_IDLE);

  dltq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  dltq_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (tick_length),
    .done    (div_done),
    .quotient(div_quotient)
  );

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    pos_next        = pos;
    rem_next        = rem;
    hold_delta_next = hold_delta;
    ins_handle_next = ins_handle;
    ins_period_next = ins_period;
    readd_next      = readd;
    result_next     = result;
    res_valid_next  = res_valid && !res_ready;
    res_next        = res;
    ram_we          = 1'b0;
    ram_waddr       = idx;
    ram_wdata       = rd;
    ram_raddr       = '0;
    div_start       = 1'b0;
    div_dividend    = ins_period;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          result_next = '0;
          readd_next  = 1'b0;
          unique case (cmd.kind)
            dltq_pkg::KIND_TICK: begin
              state_next = (count == '0) ? S_FINISH : S_TICK;
            end
            dltq_pkg::KIND_ADD: begin
              if (count == CW'(QUEUE_DEPTH)) begin
                result_next.status = dltq_pkg::ST_FULL;
                state_next         = S_FINISH;
              end else begin
                ins_handle_next = cmd.task_handle;
                ins_period_next = cmd.repeat_period;
                div_start       = 1'b1;
                div_dividend    = cmd.first_delay;
                state_next      = S_DIV;
              end
            end
            dltq_pkg::KIND_DELETE: begin
              if (SW'(cmd.slot) >= SW'(count)) begin
                result_next.status = dltq_pkg::ST_IGNORED;
                state_next         = S_FINISH;
              end else if (SW'(cmd.slot) == SW'(count) - 1'b1) begin
                count_next = count - 1'b1;
                state_next = S_FINISH;
              end else begin
                pos_next   = IW'(cmd.slot);
                ram_raddr  = IW'(cmd.slot);
                state_next = S_REM_HEAD;
              end
            end
            dltq_pkg::KIND_DISPATCH: begin
              if (count == '0) begin
                result_next.status = dltq_pkg::ST_NONE;
                state_next         = S_FINISH;
              end else begin
                state_next = S_DISP;
              end
            end
          endcase
        end
      end

      S_DIV: begin
        if (div_done) begin
          rem_next = div_quotient;
          idx_next = '0;
          pos_next = '0;
          state_next = (count == '0) ? S_PLACE : S_WALK;
        end
      end

      S_WALK: begin
        if (rem > rd.delta) begin
          rem_next = rem - rd.delta;
          if (idx == count_last) begin
            pos_next   = IW'(count);
            state_next = S_PLACE;
          end else begin
            idx_next  = IW'(idx + 1'b1);
            ram_raddr = IW'(idx + 1'b1);
          end
        end else begin
          hold_delta_next = rd.delta - rem;
          pos_next        = idx;
          idx_next        = count_last;
          ram_raddr       = count_last;
          state_next      = S_SHIFT;
        end
      end

      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(idx + 1'b1);
        if (idx == pos) begin
          ram_wdata.delta = hold_delta;
          state_next      = S_PLACE;
        end else begin
          idx_next  = IW'(idx - 1'b1);
          ram_raddr = IW'(idx - 1'b1);
        end
      end

      S_PLACE: begin
        ram_we                  = 1'b1;
        ram_waddr               = pos;
        ram_wdata.handle        = ins_handle;
        ram_wdata.delta         = rem;
        ram_wdata.period        = ins_period;
        count_next              = count + 1'b1;
        result_next.placed_slot = dltq_pkg::SLOT_W'(pos);
        state_next              = S_FINISH;
      end

      S_REM_HEAD: begin
        hold_delta_next = rd.delta;
        idx_next        = IW'(pos + 1'b1);
        ram_raddr       = IW'(pos + 1'b1);
        state_next      = S_REM_SHIFT;
      end

      S_REM_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(idx - 1'b1);
        if (idx == IW'(pos + 1'b1)) begin
          ram_wdata.delta = fold_delta;
        end
        if (idx == count_last) begin
          count_next = count - 1'b1;
          if (readd) begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end else begin
            state_next = S_FINISH;
          end
        end else begin
          idx_next  = IW'(idx + 1'b1);
          ram_raddr = IW'(idx + 1'b1);
        end
      end

      S_DISP: begin
        if (rd.delta != '0) begin
          result_next.status = dltq_pkg::ST_NONE;
          state_next         = S_FINISH;
        end else begin
          result_next.fired_valid  = 1'b1;
          result_next.fired_handle = rd.handle;
          ins_handle_next          = rd.handle;
          ins_period_next          = rd.period;
          readd_next               = (rd.period != '0);
          if (count == CW'(1)) begin
            count_next = '0;
            if (rd.period != '0) begin
              div_start    = 1'b1;
              div_dividend = rd.period;
              state_next   = S_DIV;
            end else begin
              state_next = S_FINISH;
            end
          end else begin
            pos_next        = '0;
            hold_delta_next = '0;
            idx_next        = IW'(1);
            ram_raddr       = IW'(1);
            state_next      = S_REM_SHIFT;
          end
        end
      end

      S_TICK: begin
        if (rd.delta != '0) begin
          ram_we          = 1'b1;
          ram_waddr       = '0;
          ram_wdata.delta = rd.delta - 1'b1;
        end
        state_next = S_FINISH;
      end

      S_FINISH: begin
        if (!res_valid || res_ready) begin
          res_valid_next = 1'b1;
          res_next       = result;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      res_valid   <= 1'b0;
      tick_length <= dltq_pkg::TICK_RESET;
    end else begin
      state     <= state_next;
      count     <= count_next;
      res_valid <= res_valid_next;
      if (cfg_we) begin
        tick_length <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    pos        <= pos_next;
    rem        <= rem_next;
    hold_delta <= hold_delta_next;
    ins_handle <= ins_handle_next;
    ins_period <= ins_period_next;
    readd      <= readd_next;
    result     <= result_next;
    res        <= res_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> count <= CW'(QUEUE_DEPTH))
    else $error("Entry count exceeds the queue depth.");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_SHIFT || state == S_PLACE ||
                state == S_REM_SHIFT || state == S_TICK))
    else $error("RAM written outside a list update.");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      (count == $past(count) + 1'b1 || count == $past(count) - 1'b1))
    else $error("Entry count moved by more than one.");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("Divider finished outside the divide state.");

  a_finish_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && (!res_valid || res_ready)) |=>
      (res_valid && state == S_IDLE))
    else $error("Finished request did not reach the output.");

endmodule
